### sv/aes_pkg.sv
package aes_pkg;

  localparam int unsigned RoundKeys = 11;
  localparam int unsigned KeyWords  = 2 * RoundKeys;
  localparam int unsigned KwAddrW   = 5;

  typedef enum logic [2:0] {
    CfgMode    = 3'd0,
    CfgKeyUp   = 3'd1,
    CfgKeyLo   = 3'd2,
    CfgIvUp    = 3'd3,
    CfgIvLo    = 3'd4
  } cfg_idx_e;

  localparam logic [7:0] FwdSub [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSub [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] RoundConst [RoundKeys] = '{
    8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  function automatic logic [7:0] gf_dbl(input logic [7:0] x);
    gf_dbl = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a 128-bit block sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int unsigned i);
    byte_at = s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] sub_shift_fwd(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = FwdSub[byte_at(s, r + 4 * ((c + r) % 4))];
      end
    end
    sub_shift_fwd = t;
  endfunction

  function automatic logic [127:0] sub_shift_inv(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8] = InvSub[byte_at(s, r + 4 * c)];
      end
    end
    sub_shift_inv = t;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a, b, d, e, x;
    t = s;
    for (int c = 0; c < 4; c++) begin
      a = byte_at(s, 4 * c);
      b = byte_at(s, 4 * c + 1);
      d = byte_at(s, 4 * c + 2);
      e = byte_at(s, 4 * c + 3);
      x = a ^ b ^ d ^ e;
      t[127 - 32 * c -: 8]       = a ^ x ^ gf_dbl(a ^ b);
      t[127 - 32 * c - 8 -: 8]   = b ^ x ^ gf_dbl(b ^ d);
      t[127 - 32 * c - 16 -: 8]  = d ^ x ^ gf_dbl(d ^ e);
      t[127 - 32 * c - 24 -: 8]  = e ^ x ^ gf_dbl(e ^ a);
    end
    mix_fwd = t;
  endfunction

  // inverse mix as a preconditioning step followed by the forward mix
  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a, b, d, e, u, v;
    t = s;
    for (int c = 0; c < 4; c++) begin
      a = byte_at(s, 4 * c);
      b = byte_at(s, 4 * c + 1);
      d = byte_at(s, 4 * c + 2);
      e = byte_at(s, 4 * c + 3);
      u = gf_dbl(gf_dbl(a ^ d));
      v = gf_dbl(gf_dbl(b ^ e));
      t[127 - 32 * c -: 8]      = a ^ u;
      t[127 - 32 * c - 8 -: 8]  = b ^ v;
      t[127 - 32 * c - 16 -: 8] = d ^ u;
      t[127 - 32 * c - 24 -: 8] = e ^ v;
    end
    mix_inv = mix_fwd(t);
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] t, w0, w1, w2, w3;
    t = {FwdSub[k[23:16]] ^ rc, FwdSub[k[15:8]], FwdSub[k[7:0]], FwdSub[k[31:24]]};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    key_next = {w0, w1, w2, w3};
  endfunction

endpackage

### sv/aes_ram.sv
module aes_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

### sv/aes128_cbc_cipher.sv
// AES-128 CBC engine. One 128-bit block per item; the CfgMode register
// selects encrypt or decrypt. At the first item of a message (after reset or
// after an item with tlast) the key is expanded into the round key RAMs, one
// round key per cycle (two 64-bit words written per cycle), and the IV is
// loaded as chain value. Each block then takes one round per cycle: a RAM
// prefetch and 11 key rounds from acceptance to result, limited by the single
// round datapath and the registered key RAM read; the first block of a
// message also passes the key expansion. The next item is accepted once the
// result has moved to the output register.
module aes128_cbc_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [127:0] s_axis_tdata_i,   // block_upper[63:0], block_lower[127:64]
  input  logic         s_axis_tlast_i,   // block_is_last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // result_upper[63:0], result_lower[127:64]
  output logic         m_axis_tlast_o    // result_is_last
);
  import aes_pkg::*;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StExp   = 4'b0010,
    StRound = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic         mode_q;
  logic [127:0] key_q, iv_q, chain_q;
  logic         start_q;
  logic [127:0] blk_q, st_q, ek_q;
  logic         last_q, dec_q;
  logic [3:0]   cnt_q;
  logic [127:0] out_q;
  logic         out_last_q, out_vld_q;

  // round key RAMs: one for each 64-bit half
  logic           rk_we;
  logic [KwAddrW-2:0] rk_waddr, rk_raddr;
  logic [63:0]    rk_hi, rk_lo;

  aes_ram #(.Width(64), .Depth(RoundKeys)) u_rk_hi (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(ek_q[127:64]),
    .raddr_i(rk_raddr), .rdata_o(rk_hi)
  );
  aes_ram #(.Width(64), .Depth(RoundKeys)) u_rk_lo (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(ek_q[63:0]),
    .raddr_i(rk_raddr), .rdata_o(rk_lo)
  );

  logic in_acc, out_acc, last_rnd;
  logic [127:0] rk, res;
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o & m_axis_tready_i;
  assign rk      = {rk_hi, rk_lo};
  assign last_rnd = (cnt_q == 4'd10);

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {out_q[63:0], out_q[127:64]};
  assign m_axis_tlast_o  = out_last_q;

  assign rk_we    = (state_q == StExp);
  assign rk_waddr = cnt_q;

  // round key read order: prefetch one ahead of the round counter
  logic [3:0] rd_idx;
  always_comb begin
    priority if (state_q == StRound && !last_rnd) begin
      rd_idx = dec_q ? 4'd9 - cnt_q : cnt_q + 4'd1;
    end else if (state_q == StRound) begin
      // hold the final round key while the result waits
      rd_idx = dec_q ? 4'd0 : 4'd10;
    end else begin
      rd_idx = dec_q ? 4'd10 : 4'd0;
    end
  end
  assign rk_raddr = rd_idx;

  // one round of the datapath
  logic [127:0] rnd;
  always_comb begin
    priority if (cnt_q == 4'd0) begin
      rnd = dec_q ? (blk_q ^ rk) : (blk_q ^ chain_q ^ rk);
    end else if (dec_q) begin
      rnd = sub_shift_inv(st_q) ^ rk;
      if (!last_rnd) rnd = mix_inv(rnd);
    end else begin
      rnd = sub_shift_fwd(st_q);
      if (!last_rnd) rnd = mix_fwd(rnd);
      rnd = rnd ^ rk;
    end
  end
  assign res = dec_q ? (rnd ^ chain_q) : rnd;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = start_q ? StExp : StDone;
      StExp:   if (cnt_q == 4'd10) state_d = StDone;
      StDone:  state_d = StRound;  // key RAM prefetch cycle
      StRound: if (last_rnd && !out_vld_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      mode_q    <= 1'b0;
      key_q     <= '0;
      iv_q      <= '0;
      chain_q   <= '0;
      start_q   <= 1'b1;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgMode:  mode_q <= cfg_data_i[0];
          CfgKeyUp: key_q[127:64] <= cfg_data_i;
          CfgKeyLo: key_q[63:0]   <= cfg_data_i;
          CfgIvUp:  iv_q[127:64]  <= cfg_data_i;
          CfgIvLo:  iv_q[63:0]    <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_acc) out_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          cnt_q <= '0;
          if (in_acc && start_q) chain_q <= iv_q;
        end
        StExp: cnt_q <= (cnt_q == 4'd10) ? 4'd0 : cnt_q + 4'd1;
        StDone: cnt_q <= '0;
        StRound: begin
          if (!last_rnd) begin
            cnt_q <= cnt_q + 4'd1;
          end else if (!out_vld_q) begin
            out_vld_q <= 1'b1;
            chain_q   <= dec_q ? blk_q : res;
            start_q   <= last_q;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      blk_q  <= {s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]};
      last_q <= s_axis_tlast_i;
      dec_q  <= mode_q;
      ek_q   <= key_q;
    end
    if (state_q == StExp && !last_rnd) begin
      ek_q <= key_next(ek_q, RoundConst[cnt_q + 4'd1]);
    end
    if (state_q == StRound) begin
      if (!last_rnd) st_q <= rnd;
      else if (!out_vld_q) begin
        out_q      <= res;
        out_last_q <= last_q;
      end
    end
  end

`ifndef ASSERT_OFF
  // key RAM is written only during expansion
  a_we_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rk_we |-> state_q == StExp) else $error("key write outside expansion");
  // a result appears only from the last round
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == StRound && last_rnd))
    else $error("result without last round");
  // round counter stays in range
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd10) else $error("round counter overflow");
  // input is not taken while busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !s_axis_tready_o) else $error("ready while busy");
`endif
endmodule
